// ----- hdl/shl_pkg.sv -----
// Package for the sorted hit list: transaction structs, function codes,
// and the link and report structs passed between list cells. No dependencies.
`timescale 1ns / 1ps

package shl_pkg;

   // Sizing defaults
   localparam int LIST_DEPTH_DEFAULT  = 16;
   localparam int OBJECT_BITS_DEFAULT = 8;
   localparam int OBJ_MAX_W           = 16;

   // Function codes
   localparam logic [1:0] FUNC_QUERY  = 2'd0;
   localparam logic [1:0] FUNC_INSERT = 2'd1;
   localparam logic [1:0] FUNC_CLEAR  = 2'd2;

   typedef struct packed {
      logic [1:0]         func;
      logic signed [31:0] t_value;
      logic [7:0]         object_id;
      logic [3:0]         read_index;
   } req_type;

   typedef struct packed {
      logic [4:0]         entry_total;
      logic               has_hit;
      logic signed [31:0] hit_t;
      logic [7:0]         hit_object;
      logic signed [31:0] read_t;
      logic [7:0]         read_object;
      logic               overflow;
   } rsp_type;

   // Data handed from one cell to its right neighbor
   typedef struct packed {
      logic                 valid;   // valid after a pending clear
      logic signed [31:0]   t;
      logic [OBJ_MAX_W-1:0] obj;
      logic                 keep;    // entry stays put on insert
      logic                 neg;     // stored entry is valid and negative
   } shl_link_type;

   // Per-cell contribution to the result, zero unless selected
   typedef struct packed {
      logic                 hit;
      logic signed [31:0]   hit_t;
      logic [OBJ_MAX_W-1:0] hit_obj;
      logic signed [31:0]   rd_t;
      logic [OBJ_MAX_W-1:0] rd_obj;
   } shl_report_type;

endpackage

// ----- hdl/shl_cell.sv -----
// One list position: holds an entry, takes the new entry or its left neighbor's
// entry on insert, and reports its entry when it is the hit or the read target. Uses shl_pkg.
`timescale 1ns / 1ps

module shl_cell #(
   parameter int CELL_INDEX  = 0,
   parameter int OBJECT_BITS = shl_pkg::OBJECT_BITS_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           ins,
   input  logic                           clr,
   input  logic signed [31:0]             new_t,
   input  logic [shl_pkg::OBJ_MAX_W-1:0]  new_obj,
   input  logic [3:0]                     rd_idx,
   input  shl_pkg::shl_link_type          left,
   output shl_pkg::shl_link_type          right,
   output shl_pkg::shl_report_type        report
);
   import shl_pkg::*;

   logic                   valid_ff, valid_in;
   logic signed [31:0]     t_ff, t_in;
   logic [OBJECT_BITS-1:0] obj_ff, obj_in;
   logic                   eff_valid;
   logic                   keep;
   logic                   hit_sel;
   logic                   rd_sel;
   logic [OBJ_MAX_W-1:0]   obj_ext;

   // Compare against the new entry; a pending clear hides the stored one
   assign eff_valid = valid_ff & ~clr;
   assign keep      = eff_valid & (t_ff < new_t);
   assign obj_ext   = OBJ_MAX_W'(obj_ff);

   assign right.valid = eff_valid;
   assign right.t     = t_ff;
   assign right.obj   = obj_ext;
   assign right.keep  = keep;
   assign right.neg   = valid_ff & t_ff[31];

   // Hold, take the new entry, or shift in from the left
   always_comb begin
      valid_in = valid_ff;
      t_in     = t_ff;
      obj_in   = obj_ff;
      if (ins) begin
         if (!keep) begin
            if (left.keep) begin
               valid_in = 1'b1;
               t_in     = new_t;
               obj_in   = new_obj[OBJECT_BITS-1:0];
            end else begin
               valid_in = left.valid;
               t_in     = left.t;
               obj_in   = left.obj[OBJECT_BITS-1:0];
            end
         end
      end else if (clr) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      t_ff   <= t_in;
      obj_ff <= obj_in;
   end

   // First nonnegative entry: left neighbor is negative, this one is not
   assign hit_sel = valid_ff & ~t_ff[31] & left.neg;
   assign rd_sel  = valid_ff & (int'({28'd0, rd_idx}) == CELL_INDEX);

   assign report.hit     = hit_sel;
   assign report.hit_t   = hit_sel ? t_ff : 32'sd0;
   assign report.hit_obj = hit_sel ? obj_ext : '0;
   assign report.rd_t    = rd_sel ? t_ff : 32'sd0;
   assign report.rd_obj  = rd_sel ? obj_ext : '0;

endmodule

// ----- hdl/sorted_hit_list_core.sv -----
// Top level of the sorted hit list: a chain of shl_cell positions, the entry
// count, and the result register. Uses shl_pkg and shl_cell.
//
//   channel   ports                      handshake
//   request   start, busy, req_data      taken when start is high and busy low
//   response  rsp_strobe, rsp_data       valid for one cycle, always taken
//
// One transaction per cycle; busy stays low. The cells update at the edge that
// takes a transaction and the result register then loads from the updated cells,
// so rsp_strobe follows start through the pend_ff and strobe_ff registers.
// Synchronous reset empties the list (valid bits and count). The receiver
// cannot stall, so no result is held back.
`timescale 1ns / 1ps

module sorted_hit_list_core #(
   parameter int LIST_DEPTH  = shl_pkg::LIST_DEPTH_DEFAULT,
   parameter int OBJECT_BITS = shl_pkg::OBJECT_BITS_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  shl_pkg::req_type req_data,
   output logic             rsp_strobe,
   output shl_pkg::rsp_type rsp_data
);
   import shl_pkg::*;

   localparam int CNT_W = $clog2(LIST_DEPTH + 1);

   logic                 ins;
   logic                 clr;
   logic [OBJ_MAX_W-1:0] obj_mask;
   logic [OBJ_MAX_W-1:0] new_obj;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic                 full;
   logic                 ovf_ff, ovf_in;
   logic [3:0]           rd_idx_ff;
   logic                 pend_ff;
   logic                 strobe_ff;
   rsp_type              rsp_ff, rsp_in;
   shl_report_type       merged;

   shl_link_type   links   [LIST_DEPTH+1];
   shl_report_type reports [LIST_DEPTH];

   assign busy = 1'b0;

   // Decode the transaction
   assign ins      = start & ((req_data.func == FUNC_INSERT) | (req_data.func == FUNC_CLEAR));
   assign clr      = start & (req_data.func == FUNC_CLEAR);
   assign obj_mask = OBJ_MAX_W'((17'd1 << OBJECT_BITS) - 17'd1);
   assign new_obj  = OBJ_MAX_W'(req_data.object_id) & obj_mask;
   assign full     = (count_ff == CNT_W'(LIST_DEPTH));

   // Track the entry count and overflow
   always_comb begin
      count_in = count_ff;
      ovf_in   = 1'b0;
      if (clr) begin
         count_in = CNT_W'(1);
      end else if (ins) begin
         if (full) begin
            ovf_in = 1'b1;
         end else begin
            count_in = count_ff + CNT_W'(1);
         end
      end
   end

   // Head of the chain: always ahead of the new entry, counts as negative
   assign links[0] = '{valid: 1'b0, t: 32'sd0, obj: '0, keep: 1'b1, neg: 1'b1};

   for (genvar i = 0; i < LIST_DEPTH; i++) begin : g_cell
      shl_cell #(
         .CELL_INDEX  (i),
         .OBJECT_BITS (OBJECT_BITS)
      ) u_cell (
         .clock   (clock),
         .reset   (reset),
         .ins     (ins),
         .clr     (clr),
         .new_t   (req_data.t_value),
         .new_obj (new_obj),
         .rd_idx  (rd_idx_ff),
         .left    (links[i]),
         .right   (links[i+1]),
         .report  (reports[i])
      );
   end

   // Merge the per-cell reports; at most one cell drives each field
   always_comb begin
      merged = '0;
      for (int i = 0; i < LIST_DEPTH; i++) begin
         merged = merged | reports[i];
      end
   end

   always_comb begin
      rsp_in             = '0;
      rsp_in.entry_total = 5'(count_ff);
      rsp_in.has_hit     = merged.hit;
      rsp_in.hit_t       = merged.hit_t;
      rsp_in.hit_object  = merged.hit_obj[7:0];
      rsp_in.read_t      = merged.rd_t;
      rsp_in.read_object = merged.rd_obj[7:0];
      rsp_in.overflow    = ovf_ff;
   end

   // Advance the transaction: cell update, then result register
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         pend_ff   <= 1'b0;
         strobe_ff <= 1'b0;
      end else begin
         count_ff  <= count_in;
         pend_ff   <= start;
         strobe_ff <= pend_ff;
      end
      ovf_ff    <= ovf_in;
      rd_idx_ff <= req_data.read_index;
      rsp_ff    <= rsp_in;
   end

   assign rsp_strobe = strobe_ff;
   assign rsp_data   = rsp_ff;

   // Checks
   a_strobe_follows_start: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(pend_ff))
      else $error("result strobe without a taken transaction");

   a_hit_nonnegative: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_data.has_hit |-> !rsp_data.hit_t[31])
      else $error("reported hit has negative t");

   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(LIST_DEPTH))
      else $error("entry count above list depth");

   a_overflow_when_full: assert property (@(posedge clock) disable iff (reset)
      ovf_in |-> full && !clr)
      else $error("overflow flagged on a list that was not full");

endmodule

// ----- bench/tb_top.sv -----
`timescale 1ns / 1ps
// Testbench for sorted_hit_list_core: directed and random transactions checked
// against a behavioral model of the sorted hit list. Depends on shl_pkg and the core.

module tb_top;
   import shl_pkg::*;

   localparam int         DEPTH        = LIST_DEPTH_DEFAULT;
   localparam int         OBJ_BITS     = OBJECT_BITS_DEFAULT;
   localparam logic [1:0] FUNC_SPARE   = 2'd3;
   localparam int         CYCLE_LIMIT  = 200000;
   localparam int         DRAIN_CYCLES = 4;
   localparam logic signed [31:0] T_MIN = 32'sh8000_0000;
   localparam logic signed [31:0] T_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [31:0] T_ONE = 32'sh0001_0000;

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   logic    rsp_strobe;
   req_type req_data;
   rsp_type rsp_data;

   // Model of the list contents, updated once per accepted transaction
   logic signed [31:0] model_t [DEPTH];
   logic [7:0]         model_obj [DEPTH];
   int                 model_count;

   rsp_type pending_reports [$];
   int      error_count;
   int      items_sent;
   int      results_seen;
   int      hits_seen;
   int      overflows_seen;
   int      cycle_count;

   sorted_hit_list_core dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

   // 8 ns clock
   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   // Apply one transaction to the model and return the report it should produce
   function automatic rsp_type predict_hit_list(req_type item);
      rsp_type            r;
      int                 pos;
      int                 i;
      logic signed [31:0] new_t;
      logic [7:0]         new_obj;
      r = '0;
      new_t = item.t_value;
      new_obj = item.object_id & 8'((1 << OBJ_BITS) - 1);
      if (item.func == FUNC_CLEAR)
         model_count = 0;
      if (item.func == FUNC_INSERT || item.func == FUNC_CLEAR) begin
         pos = 0;
         while (pos < model_count && model_t[pos] < new_t)
            pos++;
         if (model_count >= DEPTH)
            r.overflow = 1'b1;
         else
            model_count++;
         // Shift the tail right; on a full list the last entry falls off
         if (pos < DEPTH) begin
            for (i = model_count - 1; i > pos; i--) begin
               model_t[i] = model_t[i - 1];
               model_obj[i] = model_obj[i - 1];
            end
            model_t[pos] = new_t;
            model_obj[pos] = new_obj;
         end
      end
      for (i = 0; i < model_count; i++) begin
         if (!r.has_hit && !model_t[i][31]) begin
            r.has_hit = 1'b1;
            r.hit_t = model_t[i];
            r.hit_object = model_obj[i];
         end
      end
      if (item.read_index < model_count) begin
         r.read_t = model_t[item.read_index];
         r.read_object = model_obj[item.read_index];
      end
      r.entry_total = 5'(model_count);
      return r;
   endfunction

   function automatic void flag_mismatch(string field, logic [31:0] want, logic [31:0] got);
      error_count++;
      $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
   endfunction

   // Predict on each accepted transaction, then check each strobed result
   always @(posedge clock) begin
      rsp_type want;
      rsp_type got;
      if (!reset && start && !busy) begin
         pending_reports = {pending_reports, predict_hit_list(req_data)};
         items_sent++;
      end
      if (!reset && rsp_strobe) begin
         got = rsp_data;
         results_seen++;
         if (pending_reports.size() == 0) begin
            error_count++;
            $display("%0t ns: unexpected result, actual %h", $time, got);
         end else begin
            want = pending_reports.pop_front();
            if (got.entry_total !== want.entry_total)
               flag_mismatch("entry_total", 32'(want.entry_total), 32'(got.entry_total));
            if (got.has_hit !== want.has_hit)
               flag_mismatch("has_hit", 32'(want.has_hit), 32'(got.has_hit));
            if (got.hit_t !== want.hit_t)
               flag_mismatch("hit_t", want.hit_t, got.hit_t);
            if (got.hit_object !== want.hit_object)
               flag_mismatch("hit_object", 32'(want.hit_object), 32'(got.hit_object));
            if (got.read_t !== want.read_t)
               flag_mismatch("read_t", want.read_t, got.read_t);
            if (got.read_object !== want.read_object)
               flag_mismatch("read_object", 32'(want.read_object), 32'(got.read_object));
            if (got.overflow !== want.overflow)
               flag_mismatch("overflow", 32'(want.overflow), 32'(got.overflow));
            if (want.has_hit)
               hits_seen++;
            if (want.overflow)
               overflows_seen++;
         end
      end
   end

   // Abort a hung run
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t ns: cycle limit reached, %0d results outstanding",
                  $time, pending_reports.size());
         $display("TB_ERROR");
         $finish;
      end
   end

   function automatic req_type make_item(logic [1:0] func, logic signed [31:0] t,
                                         logic [7:0] obj, logic [3:0] idx);
      req_type item;
      item.func = func;
      item.t_value = t;
      item.object_id = obj;
      item.read_index = idx;
      return item;
   endfunction

   // Mix full-range, near-zero, extreme and already stored distances
   function automatic logic signed [31:0] pick_distance();
      logic signed [31:0] t;
      case ($urandom_range(0, 4))
         0, 1: t = $urandom;
         2: t = (32'($urandom_range(0, 16)) - 32'sd8) <<< $urandom_range(0, 16);
         3: begin
            case ($urandom_range(0, 3))
               0: t = T_MIN;
               1: t = T_MAX;
               2: t = 32'sd0;
               default: t = -32'sd1;
            endcase
         end
         default: begin
            if (model_count > 0)
               t = model_t[$urandom_range(0, model_count - 1)];
            else
               t = $urandom;
         end
      endcase
      return t;
   endfunction

   // Hold start and the payload until the core takes the transaction
   task automatic send_item(input req_type item);
      start <= 1'b1;
      req_data <= item;
      @(posedge clock);
      while (busy)
         @(posedge clock);
   endtask

   task automatic pause_sender(input int cycles);
      start <= 1'b0;
      req_data <= req_type'($bits(req_type)'({$urandom, $urandom}));
      repeat (cycles)
         @(posedge clock);
   endtask

   task automatic maybe_idle();
      if ($urandom_range(0, 3) == 0)
         pause_sender($urandom_range(1, 6));
   endtask

   // Stop sending until every predicted result has been checked
   task automatic wait_for_results();
      start <= 1'b0;
      @(posedge clock);
      while (pending_reports.size() != 0)
         @(posedge clock);
   endtask

   task automatic test_empty_list();
      send_item(make_item(FUNC_QUERY, 32'sd0, 8'h00, 4'd0));
      send_item(make_item(FUNC_SPARE, T_MAX, 8'hFF, 4'd15));
      wait_for_results();
   endtask

   // Ordering, ties, sign boundary and reads beyond the count
   task automatic test_basic_order();
      send_item(make_item(FUNC_CLEAR, T_MIN, 8'h01, 4'd0));
      send_item(make_item(FUNC_INSERT, T_MAX, 8'hFF, 4'd1));
      send_item(make_item(FUNC_INSERT, 32'sd0, 8'h10, 4'd1));
      send_item(make_item(FUNC_INSERT, 32'sd0, 8'h20, 4'd1));
      send_item(make_item(FUNC_INSERT, -32'sd1, 8'h00, 4'd1));
      send_item(make_item(FUNC_QUERY, 32'sd0, 8'h00, 4'd15));
      send_item(make_item(FUNC_QUERY, 32'sd0, 8'h00, 4'd4));
      wait_for_results();
   endtask

   // Fill the list, then overflow with a small entry and with oversized ones
   task automatic test_full_list();
      int k;
      for (k = 1; k <= 11; k++)
         send_item(make_item(FUNC_INSERT, T_ONE * k, 8'(k), 4'(k)));
      send_item(make_item(FUNC_INSERT, T_MIN, 8'h55, 4'd15));
      send_item(make_item(FUNC_INSERT, T_ONE * 12, 8'hAA, 4'd15));
      send_item(make_item(FUNC_INSERT, T_MAX, 8'hA5, 4'd15));
      send_item(make_item(FUNC_QUERY, 32'sd0, 8'h00, 4'd15));
      send_item(make_item(FUNC_CLEAR, -T_ONE * 5, 8'h80, 4'd0));
      wait_for_results();
   endtask

   // One fill sequence: usually a clear, then inserts mixed with queries
   task automatic run_sequence(input bit with_gaps);
      int      n;
      int      k;
      int      op;
      req_type item;
      item = make_item($urandom_range(0, 9) == 0 ? FUNC_INSERT : FUNC_CLEAR,
                       pick_distance(), 8'($urandom), 4'($urandom));
      if (with_gaps)
         maybe_idle();
      send_item(item);
      n = ($urandom_range(0, 3) == 0) ? $urandom_range(14, 22) : $urandom_range(1, 10);
      for (k = 0; k < n; k++) begin
         op = $urandom_range(0, 9);
         item = make_item(op < 7 ? FUNC_INSERT : (op < 9 ? FUNC_QUERY : FUNC_SPARE),
                          pick_distance(), 8'($urandom), 4'($urandom));
         if (with_gaps)
            maybe_idle();
         send_item(item);
      end
   endtask

   task automatic test_random_sequences(input int count);
      int first;
      int drained;
      first = items_sent;
      drained = 0;
      while (items_sent - first < count) begin
         run_sequence(1'b1);
         // Drain once midway
         if (!drained && items_sent - first > count / 2) begin
            wait_for_results();
            drained = 1;
         end
      end
   endtask

   task automatic test_streaming(input int count);
      int first;
      first = items_sent;
      while (items_sent - first < count)
         run_sequence(1'b0);
   endtask

   initial begin
      reset <= 1'b1;
      start <= 1'b0;
      req_data <= '0;
      model_count = 0;
      error_count = 0;
      items_sent = 0;
      results_seen = 0;
      hits_seen = 0;
      overflows_seen = 0;
      cycle_count = 0;
      repeat (6)
         @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_empty_list();
      test_basic_order();
      test_full_list();
      test_random_sequences(850);
      test_streaming(150);

      wait_for_results();
      repeat (DRAIN_CYCLES)
         @(posedge clock);
      $display("Sent %0d transactions, checked %0d results (%0d with a hit, %0d overflows)",
               items_sent, results_seen, hits_seen, overflows_seen);
      $display("Covered empty, tied, full and overflowing lists with and without sender gaps");
      if (error_count == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule
